FILE: rtl/oss_pkg.sv
package oss_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_KTH    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADRANK = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_KTH,
      ST_KTH_WAIT,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/oss_req_if.sv
interface oss_req_if;
   logic                                valid;
   logic                                ready;
   logic [oss_pkg::CMD_W-1:0]           cmd;
   logic signed [oss_pkg::DATA_W-1:0]   operand;

   modport source (output valid, output cmd, output operand, input ready);
   modport sink   (input valid, input cmd, input operand, output ready);
endinterface

FILE: rtl/oss_rsp_if.sv
interface oss_rsp_if #(
   parameter int CNT_W = 7
);
   logic                                valid;
   logic                                ready;
   logic signed [oss_pkg::DATA_W-1:0]   result_value;
   logic [oss_pkg::STATUS_W-1:0]        status;
   logic [CNT_W-1:0]                    set_size;

   modport source (output valid, output result_value, output status, output set_size,
                   input ready);
   modport sink   (input valid, input result_value, input status, input set_size,
                   output ready);
endinterface

FILE: rtl/oss_ram.sv
module oss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/order_statistic_set_top.sv
// insert, delete and count: binary search, at most ceil(log2(n+1)) probes for n held values;
// kth reads the value at rank k directly, or answers with a bad rank status
// insert and delete then move entries one at a time, insert then writes the new value
// throughput: one item at a time, the next is taken in the cycle after the result is loaded,
// even while that beat still waits; a stalled beat holds the next result back
// reset: synchronous, active high; empties the set, value ram contents are not cleared
module order_statistic_set_top #(
   parameter int CAPACITY = oss_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   oss_req_if.sink   req_if,
   oss_rsp_if.source rsp_if
);
   import oss_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic                    found_ff, found_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DATA_W-1:0]       res_ff, res_in;
   logic [STATUS_W-1:0]     stat_ff, stat_in;

   logic                    out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]       out_res_ff, out_res_in;
   logic [STATUS_W-1:0]     out_stat_ff, out_stat_in;
   logic [CNT_W-1:0]        out_size_ff, out_size_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic [AW-1:0]           rd_addr;
   logic [DATA_W-1:0]       rd_data;

   logic [CNT_W:0]          mid_sum;
   logic [DATA_W-1:0]       rank_m1;
   logic                    rank_bad;
   logic [CNT_W-1:0]        idx_dec;
   logic [CNT_W-1:0]        idx_inc;

   oss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rank_m1  = key_ff - 32'sd1;
   assign rank_bad = (key_ff == '0) || key_ff[DATA_W-1] ||
                     (key_ff > $signed(DATA_W'(cnt_ff)));
   assign idx_dec  = idx_ff - 1'b1;
   assign idx_inc  = idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      out_res_ff  <= out_res_in;
      out_stat_ff <= out_stat_in;
      out_size_ff <= out_size_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_stat_in  = out_stat_ff;
      out_size_in  = out_size_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = key_ff;
      rd_addr      = '0;
      req_if.ready = (state_ff == ST_IDLE);

      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.cmd;
               key_in   = req_if.operand;
               lo_in    = '0;
               hi_in    = cnt_ff;
               found_in = 1'b0;
               res_in   = '0;
               stat_in  = STATUS_OK;
               state_in = (req_if.cmd == CMD_KTH) ? ST_KTH : ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            mid_in  = mid_sum[CNT_W:1];
            rd_addr = mid_sum[AW:1];
            if (lo_ff < hi_ff) begin
               state_in = ST_SRCH_CMP;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_SRCH_CMP: begin
            if ($signed(rd_data) < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            if ($signed(rd_data) == key_ff) begin
               found_in = 1'b1;
            end
            state_in = ST_SRCH_RD;
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (found_ff) begin
                     stat_in = STATUS_IGNORED;
                  end else if ({1'b0, cnt_ff} >= (CNT_W + 1)'(CAPACITY)) begin
                     stat_in = STATUS_FULL;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = (cnt_ff > lo_ff) ? ST_SHIFT_RD : ST_PUT;
                  end
               end
               CMD_DELETE: begin
                  if (!found_ff) begin
                     stat_in = STATUS_IGNORED;
                  end else begin
                     cnt_in = cnt_ff - 1'b1;
                     idx_in = lo_ff;
                     if (({1'b0, lo_ff} + 1'b1) < {1'b0, cnt_ff}) begin
                        state_in = ST_SHIFT_RD;
                     end
                  end
               end
               default: begin
                  res_in = DATA_W'(lo_ff);
               end
            endcase
         end
         ST_SHIFT_RD: begin
            rd_addr  = (cmd_ff == CMD_INSERT) ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            if (cmd_ff == CMD_INSERT) begin
               idx_in   = idx_dec;
               state_in = (idx_dec > lo_ff) ? ST_SHIFT_RD : ST_PUT;
            end else begin
               idx_in   = idx_inc;
               state_in = (idx_inc < cnt_ff) ? ST_SHIFT_RD : ST_RESP;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = key_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_RESP;
         end
         ST_KTH: begin
            rd_addr = rank_m1[AW-1:0];
            if (rank_bad) begin
               stat_in  = STATUS_BADRANK;
               state_in = ST_RESP;
            end else begin
               state_in = ST_KTH_WAIT;
            end
         end
         ST_KTH_WAIT: begin
            res_in   = rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               out_res_in   = res_ff;
               out_stat_in  = stat_ff;
               out_size_in  = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_value = out_res_ff;
   assign rsp_if.status       = out_stat_ff;
   assign rsp_if.set_size     = out_size_ff;
endmodule

FILE: rtl/oss_checker.sv
module oss_checker #(
   parameter int CAPACITY = oss_pkg::CAPACITY_DEF
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic [oss_pkg::DATA_W-1:0]               rsp_result_value,
   input logic [oss_pkg::STATUS_W-1:0]             rsp_status,
   input logic [$clog2(CAPACITY + 1)-1:0]          rsp_set_size
);
   import oss_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
      $stable(rsp_status) && $stable(rsp_set_size))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item still in work");

   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_set_size == CNT_W'(CAPACITY))
      else $error("store full reported below capacity");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_set_size} <= (CNT_W + 1)'(CAPACITY)))
      else $error("set size above capacity");
endmodule

bind order_statistic_set_top oss_checker #(
   .CAPACITY (CAPACITY)
) u_oss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.result_value),
   .rsp_status       (rsp_if.status),
   .rsp_set_size     (rsp_if.set_size)
);
